>>> sv/mmlp_pkg.sv
// ----------------------------------------------------------------------------
// mmlp_pkg
// Shared types, codes and character constants for the memory map line parser.
// ----------------------------------------------------------------------------
package mmlp_pkg;

   localparam int CharWidth  = 8;
   localparam int PhaseWidth = 4;
   localparam int RspWidth   = 336;
   localparam int RecWidth   = 329;

   // parser phases
   localparam logic [PhaseWidth-1:0] PH_START0 = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_START1 = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_END    = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_PERM   = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_OFFSET = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_MAJOR  = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_MINOR  = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_INODE  = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_PATH   = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_ERR    = 4'd9;
   localparam logic [PhaseWidth-1:0] PH_DONE   = 4'd10;

   // record status codes
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_NO_START  = 4'd1;
   localparam logic [3:0] ST_NO_END    = 4'd2;
   localparam logic [3:0] ST_PERM_LEN  = 4'd3;
   localparam logic [3:0] ST_PERM_CHAR = 4'd4;
   localparam logic [3:0] ST_NO_OFFSET = 4'd5;
   localparam logic [3:0] ST_NO_MAJOR  = 4'd6;
   localparam logic [3:0] ST_NO_MINOR  = 4'd7;
   localparam logic [3:0] ST_NO_INODE  = 4'd8;

   localparam logic [2:0] PERM_LEN     = 3'd4;
   localparam logic [2:0] PERM_LEN_MAX = 3'd5;

   localparam logic [CharWidth-1:0] CH_DASH  = 8'h2D;
   localparam logic [CharWidth-1:0] CH_COLON = 8'h3A;
   localparam logic [CharWidth-1:0] CH_SLASH = 8'h2F;
   localparam logic [CharWidth-1:0] CH_R     = 8'h72;
   localparam logic [CharWidth-1:0] CH_W     = 8'h77;
   localparam logic [CharWidth-1:0] CH_X     = 8'h78;
   localparam logic [CharWidth-1:0] CH_S     = 8'h73;
   localparam logic [CharWidth-1:0] CH_P     = 8'h70;
   localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
   localparam logic [CharWidth-1:0] CH_CR    = 8'h0D;
   localparam logic [CharWidth-1:0] CH_0     = 8'h30;
   localparam logic [CharWidth-1:0] CH_9     = 8'h39;
   localparam logic [CharWidth-1:0] CH_LA    = 8'h61;
   localparam logic [CharWidth-1:0] CH_LF    = 8'h66;
   localparam logic [CharWidth-1:0] CH_UA    = 8'h41;
   localparam logic [CharWidth-1:0] CH_UF    = 8'h46;

   // first member lands in the top bits, start_address in the lowest
   typedef struct packed {
      logic [3:0]  status;
      logic        path_is_file;
      logic [63:0] inode_number;
      logic [31:0] device_minor;
      logic [31:0] device_major;
      logic [62:0] file_offset;
      logic [1:0]  sharing;
      logic [2:0]  protection;
      logic [63:0] end_address;
      logic [63:0] start_address;
   } record_type;

   function automatic logic is_blank(input logic [CharWidth-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

endpackage

>>> sv/mmlp_core.sv
// ----------------------------------------------------------------------------
// mmlp_core
// Parser state and per-character update; forms the record at line end.
// ----------------------------------------------------------------------------
module mmlp_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 feed_en,
   input  logic                                 line_end,
   input  logic                                 end_only,
   input  logic [mmlp_pkg::CharWidth-1:0]       ch,
   output mmlp_pkg::record_type                 record
);
   import mmlp_pkg::*;

   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic                  tok_ff, tok_in;
   logic                  stop_ff, stop_in;
   logic [63:0]           start_ff, start_in;
   logic [63:0]           end_ff, end_in;
   logic [62:0]           offset_ff, offset_in;
   logic [31:0]           major_ff, major_in;
   logic [31:0]           minor_ff, minor_in;
   logic [63:0]           inode_ff, inode_in;
   logic [4:0]            perm_ff, perm_in;
   logic [2:0]            count_ff, count_in;
   logic [3:0]            err_ff, err_in;
   logic                  file_ff, file_in;

   logic                  blank;
   logic                  dec_mode;
   logic                  digit_ok;
   logic [3:0]            digit;
   logic [63:0]           acc_sel;
   logic [67:0]           acc_sum;
   logic                  ovf64, ovf63, ovf32;
   logic                  do_take;
   logic                  acc_wr;
   logic [3:0]            status;

   assign blank    = is_blank(ch);
   assign dec_mode = (phase_ff == PH_INODE);

   always_comb begin
      digit_ok = 1'b1;
      digit    = 4'd0;
      if ((ch >= CH_0) && (ch <= CH_9)) begin
         digit = 4'(ch - CH_0);
      end else if (!dec_mode && (ch >= CH_LA) && (ch <= CH_LF)) begin
         digit = 4'(ch - CH_LA + 8'd10);
      end else if (!dec_mode && (ch >= CH_UA) && (ch <= CH_UF)) begin
         digit = 4'(ch - CH_UA + 8'd10);
      end else begin
         digit_ok = 1'b0;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_START0, PH_START1: begin
            acc_sel = start_ff;
         end
         PH_END: begin
            acc_sel = end_ff;
         end
         PH_OFFSET: begin
            acc_sel = {1'b0, offset_ff};
         end
         PH_MAJOR: begin
            acc_sel = {32'd0, major_ff};
         end
         PH_MINOR: begin
            acc_sel = {32'd0, minor_ff};
         end
         PH_INODE: begin
            acc_sel = inode_ff;
         end
         default: begin
            acc_sel = 64'd0;
         end
      endcase
   end

   // acc * base + digit; saturation when the sum leaves the field width
   assign acc_sum = (dec_mode ? ({1'b0, acc_sel, 3'd0} + {3'd0, acc_sel, 1'b0})
                              : {acc_sel, 4'd0}) + {64'd0, digit};
   assign ovf64 = |acc_sum[67:64];
   assign ovf63 = |acc_sum[67:63];
   assign ovf32 = |acc_sum[67:32];

   always_comb begin
      phase_in  = phase_ff;
      tok_in    = tok_ff;
      stop_in   = stop_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      offset_in = offset_ff;
      major_in  = major_ff;
      minor_in  = minor_ff;
      inode_in  = inode_ff;
      perm_in   = perm_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      file_in   = file_ff;
      do_take   = 1'b0;
      acc_wr    = 1'b0;

      if (!end_only) begin
         case (phase_ff)
            PH_START0, PH_START1: begin
               phase_in = PH_START1;
               if (ch == CH_DASH) begin
                  phase_in = PH_END;
               end else if (tok_ff || !blank) begin
                  do_take = 1'b1;
               end
            end
            PH_END, PH_OFFSET, PH_MINOR, PH_INODE: begin
               if (!blank) begin
                  do_take = 1'b1;
               end else if (tok_ff) begin
                  case (phase_ff)
                     PH_END:    phase_in = PH_PERM;
                     PH_OFFSET: phase_in = PH_MAJOR;
                     PH_MINOR:  phase_in = PH_INODE;
                     default:   phase_in = PH_PATH;
                  endcase
               end
            end
            PH_PERM: begin
               if (blank) begin
                  if (tok_ff) begin
                     if (count_ff != PERM_LEN) begin
                        err_in = ST_PERM_LEN;
                     end
                     phase_in = ((count_ff != PERM_LEN) || (err_ff != ST_OK)) ?
                                PH_ERR : PH_OFFSET;
                  end
               end else begin
                  tok_in = 1'b1;
                  if (count_ff < PERM_LEN_MAX) begin
                     count_in = count_ff + 3'd1;
                  end
                  case (ch)
                     CH_R:    perm_in = perm_ff | 5'b00001;
                     CH_W:    perm_in = perm_ff | 5'b00010;
                     CH_X:    perm_in = perm_ff | 5'b00100;
                     CH_S:    perm_in = perm_ff | 5'b01000;
                     CH_P:    perm_in = perm_ff | 5'b10000;
                     CH_DASH: perm_in = perm_ff;
                     default: err_in  = ST_PERM_CHAR;
                  endcase
               end
            end
            PH_MAJOR: begin
               if (ch == CH_COLON) begin
                  phase_in = PH_MINOR;
               end else if (tok_ff || !blank) begin
                  do_take = 1'b1;
               end
            end
            PH_PATH: begin
               if (!blank) begin
                  file_in  = (ch == CH_SLASH);
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end

      if (phase_in != phase_ff && phase_ff != PH_START0) begin
         tok_in  = 1'b0;
         stop_in = 1'b0;
      end

      if (do_take) begin
         tok_in = 1'b1;
         if (!stop_ff) begin
            if (!digit_ok) begin
               stop_in = 1'b1;
            end else begin
               acc_wr = 1'b1;
            end
         end
      end

      if (acc_wr) begin
         case (phase_ff)
            PH_START0, PH_START1: start_in  = ovf64 ? '1 : acc_sum[63:0];
            PH_END:               end_in    = ovf64 ? '1 : acc_sum[63:0];
            PH_OFFSET:            offset_in = ovf63 ? '1 : acc_sum[62:0];
            PH_MAJOR:             major_in  = ovf32 ? '1 : acc_sum[31:0];
            PH_MINOR:             minor_in  = ovf32 ? '1 : acc_sum[31:0];
            PH_INODE:             inode_in  = ovf64 ? '1 : acc_sum[63:0];
            default:              start_in  = start_ff;
         endcase
      end
   end

   always_comb begin
      case (phase_in)
         PH_START0: status = ST_NO_START;
         PH_START1: status = ST_NO_END;
         PH_END:    status = tok_in ? ST_PERM_LEN : ST_NO_END;
         PH_PERM: begin
            if (!tok_in || (count_in != PERM_LEN)) begin
               status = ST_PERM_LEN;
            end else begin
               status = (err_in != ST_OK) ? ST_PERM_CHAR : ST_NO_OFFSET;
            end
         end
         PH_OFFSET: status = tok_in ? ST_NO_MAJOR : ST_NO_OFFSET;
         PH_MAJOR:  status = ST_NO_MINOR;
         PH_MINOR:  status = tok_in ? ST_NO_INODE : ST_NO_MINOR;
         PH_INODE:  status = tok_in ? ST_OK : ST_NO_INODE;
         PH_ERR:    status = err_in;
         default:   status = ST_OK;
      endcase
   end

   always_comb begin
      record        = '0;
      record.status = status;
      if (status == ST_OK) begin
         record.start_address = start_in;
         record.end_address   = end_in;
         record.protection    = perm_in[2:0];
         record.sharing       = perm_in[4:3];
         record.file_offset   = offset_in;
         record.device_major  = major_in;
         record.device_minor  = minor_in;
         record.inode_number  = inode_in;
         record.path_is_file  = file_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (feed_en && line_end)) begin
         phase_ff  <= PH_START0;
         tok_ff    <= 1'b0;
         stop_ff   <= 1'b0;
         start_ff  <= '0;
         end_ff    <= '0;
         offset_ff <= '0;
         major_ff  <= '0;
         minor_ff  <= '0;
         inode_ff  <= '0;
         perm_ff   <= '0;
         count_ff  <= '0;
         err_ff    <= '0;
         file_ff   <= 1'b0;
      end else if (feed_en) begin
         phase_ff  <= phase_in;
         tok_ff    <= tok_in;
         stop_ff   <= stop_in;
         start_ff  <= start_in;
         end_ff    <= end_in;
         offset_ff <= offset_in;
         major_ff  <= major_in;
         minor_ff  <= minor_in;
         inode_ff  <= inode_in;
         perm_ff   <= perm_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
         file_ff   <= file_in;
      end
   end

endmodule

>>> sv/memory_map_line_parser.sv
// ----------------------------------------------------------------------------
// memory_map_line_parser
// Parses one memory map text line, one character per transaction, into a
// record of addresses, permissions, offset, device, inode and status.
// ----------------------------------------------------------------------------
// Takes one character per clock while the input is not stalled. Each
// transaction passes an input register and then the combinational parser
// update into the result register, which holds a line's record once the
// transaction that ends the line has passed both. The rate is set by the
// parser state loop, consuming one character per cycle unless stalled.
// A held record stalls the input only when the next queued transaction also
// ends a line.
module memory_map_line_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // ch[7:0]
   input  logic                              req_tlast,
   input  logic                              req_tuser,   // end_only
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // start_address[63:0], end_address[127:64], protection[130:128],
   // sharing[132:131], file_offset[195:133], device_major[227:196],
   // device_minor[259:228], inode_number[323:260], path_is_file[324],
   // status[328:325], zero pad[335:329]
   output logic [mmlp_pkg::RspWidth-1:0]     rsp_tdata
);
   import mmlp_pkg::*;

   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_ch_ff;
   logic                 in_last_ff;
   logic                 in_end_only_ff;
   logic                 in_ends;
   logic                 advance;
   logic                 feed_en;
   logic                 out_valid_ff;
   record_type           out_rec_ff;
   record_type           record;

   assign in_ends    = in_last_ff || in_end_only_ff;
   assign advance    = !in_ends || !out_valid_ff || rsp_tready;
   assign feed_en    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ch_ff       <= req_tdata;
         in_last_ff     <= req_tlast;
         in_end_only_ff <= req_tuser;
      end
   end

   mmlp_core u_core (
      .clock    (clock),
      .reset    (reset),
      .feed_en  (feed_en),
      .line_end (in_ends),
      .end_only (in_end_only_ff),
      .ch       (in_ch_ff),
      .record   (record)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (feed_en && in_ends) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (feed_en && in_ends) begin
         out_rec_ff <= record;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RspWidth-RecWidth)'(0), out_rec_ff};

endmodule

>>> sv/mmlp_checker.sv
// ----------------------------------------------------------------------------
// mmlp_checker
// Port-level checks for the memory map line parser, bound to the top level.
// ----------------------------------------------------------------------------
module mmlp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mmlp_pkg::RspWidth-1:0]     rsp_tdata
);
   import mmlp_pkg::*;

   // a held record keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("record changed while stalled");

   // error records carry nothing but the status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[328:325] != ST_OK) |-> (rsp_tdata[324:0] == '0))
      else $error("error record has nonzero fields");

   // a fresh record follows an accepted line-ending transaction
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && (req_tlast || req_tuser), 2))
      else $error("record without a line end");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("record valid right after reset");

endmodule

bind memory_map_line_parser mmlp_checker u_mmlp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
